// ===== hdl/bfr_pkg.sv =====
// Shared types and constants for the byte-stuffed frame receiver.
`default_nettype none
package bfr_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    localparam int LEN_W   = 9;
    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = 2;

    // Register indexes on the configuration port (word address).
    localparam logic REG_ADDRESS = 1'b0;
    localparam logic REG_CONTROL = 1'b1;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             frame_end;
        logic             escape_error;
        logic [LEN_W-1:0] payload_length;
    } res_t;

endpackage
`default_nettype wire

// ===== hdl/byte_stuffed_frame_receiver_core.sv =====
// Top level of the byte-stuffed frame receiver with its configuration registers.
// One received line byte is taken per beat on the s_ stream, and a new byte can be
// accepted every clock cycle; the per-byte state machine in the front end computes its
// next state combinationally. A result (payload byte, end of frame or escape error)
// enters the four-entry result queue when its byte is accepted and then leaves
// through the output register onto the m_ stream. The input stalls only when that queue is
// full. Configuration registers are at byte address 0 (address byte, reset 0x03) and 4
// (control byte, reset 0x00) and should be written only while the stream is idle.
`default_nettype none
module byte_stuffed_frame_receiver_core #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] data_byte, [16:8] payload_length, rest zero
    output logic             m_tlast,   // frame_end
    output logic             m_tuser,   // escape_error
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bfr_pkg::*;

    logic [7:0] address_byte_reg;
    logic [7:0] control_byte_reg;
    logic       cfg_write;
    logic       q_full;
    logic       q_push;
    logic       q_empty;
    logic       q_pop;
    res_t       push_item;
    res_t       pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            address_byte_reg <= 8'h03;
            control_byte_reg <= 8'h00;
        end else if (cfg_write) begin
            if (paddr[2] == REG_ADDRESS) address_byte_reg <= pwdata[7:0];
            if (paddr[2] == REG_CONTROL) control_byte_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_CONTROL) ? {24'b0, control_byte_reg}
                                              : {24'b0, address_byte_reg};

    bfr_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .address_byte (address_byte_reg),
        .control_byte (control_byte_reg),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (push_item)
    );

    bfr_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    bfr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_item   (pop_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule
`default_nettype wire

// ===== hdl/bfr_front.sv =====
// Front end: header match and destuffing state machine that produces result items.
`default_nettype none
module bfr_front #(
    parameter int MAX_PAYLOAD = 256
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [7:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic [7:0]    address_byte,
    input  wire logic [7:0]    control_byte,
    input  wire logic          q_full,
    output logic               q_push,
    output bfr_pkg::res_t      q_item
);
    import bfr_pkg::*;

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PAYLOAD);

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_ADDR = 3'd1;
    localparam logic [2:0] PH_CTRL = 3'd2;
    localparam logic [2:0] PH_HCHK = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_ESC  = 3'd5;

    logic [2:0]             phase_reg, phase_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       count_inc;
    logic                   in_fire;
    logic                   emit;
    logic [7:0]             emit_data;
    logic                   emit_end;
    logic                   emit_err;
    logic [CNT_W-1:0]       emit_len;
    logic [CNT_W+LEN_W-1:0] len_ext;
    logic [7:0]             b;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;
    assign b        = s_tdata;
    assign count_inc = (count_reg < CNT_MAX) ? count_reg + 1'b1 : count_reg;

    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        emit       = 1'b0;
        emit_data  = 8'h00;
        emit_end   = 1'b0;
        emit_err   = 1'b0;
        emit_len   = count_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (b == FLAG_BYTE) phase_next = PH_ADDR;
            end
            PH_ADDR: begin
                if (b == address_byte) phase_next = PH_CTRL;
                else phase_next = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
            end
            PH_CTRL: begin
                if (b == control_byte) phase_next = PH_HCHK;
                else phase_next = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
            end
            PH_HCHK: begin
                if (b == (address_byte ^ control_byte)) begin
                    phase_next = PH_DATA;
                    count_next = '0;
                end else begin
                    phase_next = (b == FLAG_BYTE) ? PH_ADDR : PH_HUNT;
                end
            end
            PH_DATA: begin
                if (b == FLAG_BYTE) begin
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                    emit_end   = 1'b1;
                end else if (b == ESC_BYTE) begin
                    phase_next = PH_ESC;
                end else begin
                    emit       = 1'b1;
                    emit_data  = b;
                    count_next = count_inc;
                    emit_len   = count_inc;
                end
            end
            PH_ESC: begin
                if (b == ESC_FLAG || b == ESC_ESC) begin
                    phase_next = PH_DATA;
                    emit       = 1'b1;
                    emit_data  = (b == ESC_FLAG) ? FLAG_BYTE : ESC_BYTE;
                    count_next = count_inc;
                    emit_len   = count_inc;
                end else begin
                    phase_next = PH_HUNT;
                    emit       = 1'b1;
                    emit_err   = 1'b1;
                end
            end
            default: begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    // The reported length is the count taken modulo 512.
    assign len_ext = {{LEN_W{1'b0}}, emit_len};

    assign q_push                = in_fire && emit;
    assign q_item.data_byte      = emit_data;
    assign q_item.frame_end      = emit_end;
    assign q_item.escape_error   = emit_err;
    assign q_item.payload_length = len_ext[LEN_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            count_reg <= '0;
        end else if (in_fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_push_needs_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_tvalid && s_tready))
        else $error("result pushed without an accepted input beat");

    a_error_rehunts: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_item.escape_error) |=> (phase_reg == PH_HUNT))
        else $error("escape error did not return to hunting");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_MAX)
        else $error("payload count passed its saturation limit");

    a_end_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_item.frame_end) |-> (q_item.data_byte == 8'h00 && !q_item.escape_error))
        else $error("end-of-frame result carries data or an error");
`endif

endmodule
`default_nettype wire

// ===== hdl/bfr_fifo.sv =====
// Small result queue between the front end and the output stage.
`default_nettype none
module bfr_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire bfr_pkg::res_t push_item,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output bfr_pkg::res_t      pop_item
);
    import bfr_pkg::*;

    res_t              mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_pop;

    assign full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty    = (count_reg == '0);
    assign do_pop   = pop && !empty;
    assign pop_item = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop) rd_ptr_reg <= rd_ptr_reg + 1'b1;
            case ({push && !full, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// ===== hdl/bfr_back.sv =====
// Output stage: takes results from the queue and holds them on the master stream.
`default_nettype none
module bfr_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          q_empty,
    input  wire bfr_pkg::res_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [23:0]        m_tdata,   // [7:0] data_byte, [16:8] payload_length, rest zero
    output logic               m_tlast,   // frame_end
    output logic               m_tuser    // escape_error
);
    import bfr_pkg::*;

    logic m_valid_reg;
    res_t out_reg;
    logic load;

    // The output register refills whenever it is empty or its beat is taken.
    assign load  = !m_valid_reg || m_tready;
    assign q_pop = load && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= !q_empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            out_reg <= q_item;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, out_reg.payload_length, out_reg.data_byte};
    assign m_tlast  = out_reg.frame_end;
    assign m_tuser  = out_reg.escape_error;

endmodule
`default_nettype wire

// ===== tb/byte_stuffed_frame_receiver_core_tb.sv =====
// Self-checking testbench for the byte-stuffed frame receiver core.
`default_nettype none
package bfr_tb_pkg;
    import bfr_pkg::*;

    typedef enum logic [2:0] {
        SEEK_FLAG,
        WANT_ADDR,
        WANT_CTRL,
        WANT_HCHK,
        IN_PAYLOAD,
        AFTER_ESC
    } rx_phase_e;

    class deframer_scoreboard;
        logic [7:0] address_value;
        logic [7:0] control_value;
        rx_phase_e  rx_phase;
        int         payload_count;
        int         max_payload;
        res_t       due_results[$];
        int         failures;

        function new(int max_len);
            max_payload   = max_len;
            address_value = 8'h03;
            control_value = 8'h00;
            rx_phase      = SEEK_FLAG;
            payload_count = 0;
            failures      = 0;
        endfunction

        function void set_reg(logic reg_idx, logic [7:0] value);
            if (reg_idx == REG_ADDRESS) begin
                address_value = value;
            end else begin
                control_value = value;
            end
        endfunction

        function void push_result(logic [7:0] data, logic is_end, logic is_err);
            res_t r;
            r.data_byte      = data;
            r.frame_end      = is_end;
            r.escape_error   = is_err;
            r.payload_length = payload_count[LEN_W-1:0];
            due_results.push_back(r);
        endfunction

        function void push_payload(logic [7:0] data);
            if (payload_count < max_payload) begin
                payload_count++;
            end
            push_result(data, 1'b0, 1'b0);
        endfunction

        // A header byte that does not match sends a flag back to the address
        // check and anything else back to hunting.
        function rx_phase_e header_miss(logic [7:0] b);
            return (b == FLAG_BYTE) ? WANT_ADDR : SEEK_FLAG;
        endfunction

        function void absorb_line_byte(logic [7:0] b);
            case (rx_phase)
                SEEK_FLAG: begin
                    if (b == FLAG_BYTE) rx_phase = WANT_ADDR;
                end
                WANT_ADDR: begin
                    rx_phase = (b == address_value) ? WANT_CTRL : header_miss(b);
                end
                WANT_CTRL: begin
                    rx_phase = (b == control_value) ? WANT_HCHK : header_miss(b);
                end
                WANT_HCHK: begin
                    if (b == (address_value ^ control_value)) begin
                        rx_phase      = IN_PAYLOAD;
                        payload_count = 0;
                    end else begin
                        rx_phase = header_miss(b);
                    end
                end
                IN_PAYLOAD: begin
                    if (b == FLAG_BYTE) begin
                        rx_phase = SEEK_FLAG;
                        push_result(8'h00, 1'b1, 1'b0);
                    end else if (b == ESC_BYTE) begin
                        rx_phase = AFTER_ESC;
                    end else begin
                        push_payload(b);
                    end
                end
                AFTER_ESC: begin
                    if (b == ESC_FLAG) begin
                        rx_phase = IN_PAYLOAD;
                        push_payload(FLAG_BYTE);
                    end else if (b == ESC_ESC) begin
                        rx_phase = IN_PAYLOAD;
                        push_payload(ESC_BYTE);
                    end else begin
                        rx_phase = SEEK_FLAG;
                        push_result(8'h00, 1'b0, 1'b1);
                    end
                end
                default: rx_phase = SEEK_FLAG;
            endcase
        endfunction

        function void match_deframed(res_t got);
            res_t want;
            if (due_results.size() == 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("unexpected beat: data %h end %b err %b len %0d",
                             got.data_byte, got.frame_end, got.escape_error,
                             got.payload_length);
                end
                return;
            end
            want = due_results.pop_front();
            if (got.data_byte !== want.data_byte || got.frame_end !== want.frame_end ||
                    got.escape_error !== want.escape_error ||
                    got.payload_length !== want.payload_length) begin
                failures++;
                if (failures <= 10) begin
                    $display("beat mismatch: want %h/%b/%b/%0d got %h/%b/%b/%0d",
                             want.data_byte, want.frame_end, want.escape_error,
                             want.payload_length, got.data_byte, got.frame_end,
                             got.escape_error, got.payload_length);
                end
            end
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        function int close_out();
            if (due_results.size() != 0) begin
                failures++;
                if (failures <= 10) begin
                    $display("%0d expected beats never arrived", due_results.size());
                end
            end
            return failures;
        endfunction
    endclass
endpackage

module byte_stuffed_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfr_pkg::*;
    import bfr_tb_pkg::*;

    localparam int MAX_PAYLOAD  = 256;
    localparam int TOTAL_BYTES  = 1650;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    deframer_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_budget;
    int bytes_sent;
    int cycle_count;

    byte_stuffed_frame_receiver_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) begin
            sb.absorb_line_byte(s_tdata);
        end
    end

    always @(posedge aclk) begin
        res_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.data_byte      = m_tdata[7:0];
            got.payload_length = m_tdata[16:8];
            got.frame_end      = m_tlast;
            got.escape_error   = m_tuser;
            sb.match_deframed(got);
        end
    end

    // Result side: random stalls, or one long hold-off when one is requested.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_budget > 0) begin
                m_tready <= 1'b0;
                hold_budget--;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    task automatic stop_sending();
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic send_payload_byte(input logic [7:0] b);
        if (b == FLAG_BYTE || b == ESC_BYTE) begin
            send_byte(ESC_BYTE);
            send_byte((b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC);
        end else begin
            send_byte(b);
        end
    endtask

    function automatic logic [7:0] pick_payload();
        logic [7:0] specials[4];
        specials = '{FLAG_BYTE, ESC_BYTE, ESC_FLAG, ESC_ESC};
        if ($urandom_range(99) < 20) return specials[$urandom_range(3)];
        return 8'($urandom);
    endfunction

    // Kinds: 0 clean frame, 1 frame broken by a bad escape, 2 corrupted header,
    // 3 line noise.
    task automatic send_random_frame(input int kind);
        logic [7:0] hdr[3];
        logic [7:0] bad;
        int len;
        int pick;
        int pos;
        if (kind == 3) begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
            return;
        end
        hdr[0] = sb.address_value;
        hdr[1] = sb.control_value;
        hdr[2] = sb.address_value ^ sb.control_value;
        if (kind == 2) begin
            pos = $urandom_range(2);
            bad = ($urandom_range(1) == 0) ? FLAG_BYTE : 8'($urandom);
            hdr[pos] = (bad == hdr[pos]) ? ~bad : bad;
        end
        pick = $urandom_range(99);
        if (pick < 85) len = $urandom_range(8);
        else if (pick < 98) len = $urandom_range(9, 40);
        else len = $urandom_range(41, 120);
        if ($urandom_range(9) == 0) send_byte(FLAG_BYTE);
        send_byte(FLAG_BYTE);
        foreach (hdr[i]) send_byte(hdr[i]);
        repeat (len) send_payload_byte(pick_payload());
        if (kind == 1) begin
            send_byte(ESC_BYTE);
            if ($urandom_range(2) == 0) begin
                bad = FLAG_BYTE;
            end else begin
                do bad = 8'($urandom); while (bad == ESC_FLAG || bad == ESC_ESC);
            end
            send_byte(bad);
        end else begin
            send_byte(FLAG_BYTE);
        end
    endtask

    task automatic send_random_until(input int target);
        int pick;
        while (bytes_sent < target) begin
            pick = $urandom_range(99);
            if (pick < 75) send_random_frame(0);
            else if (pick < 85) send_random_frame(1);
            else if (pick < 93) send_random_frame(2);
            else send_random_frame(3);
        end
        stop_sending();
    endtask

    task automatic wait_idle();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_access(input logic is_write, input logic reg_idx,
                              input logic [7:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= {24'h0, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (is_write) begin
            sb.set_reg(reg_idx, value);
        end else if (prdata !== {24'h0, value}) begin
            sb.failures++;
            if (sb.failures <= 10) begin
                $display("register read mismatch: index %0d want %h got %h",
                         reg_idx, value, prdata);
            end
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_header(input logic [7:0] addr_val, input logic [7:0] ctrl_val);
        apb_access(1'b1, REG_ADDRESS, addr_val);
        apb_access(1'b1, REG_CONTROL, ctrl_val);
        apb_access(1'b0, REG_ADDRESS, addr_val);
        apb_access(1'b0, REG_CONTROL, ctrl_val);
    endtask

    initial begin
        logic [7:0] directed_line[30];
        logic [7:0] addr_set[3];
        logic [7:0] ctrl_set[3];
        int stall_set[3];
        int idle_set[3];

        // Reset header is address 0x03, control 0x00, check byte 0x03.
        directed_line = '{
            8'h00, 8'h7E, 8'h7E, 8'h03, 8'h00, 8'h03,
            8'h00, 8'hFF, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h7E,
            8'h7E, 8'h03, 8'h55,
            8'h7E, 8'h03, 8'h00, 8'h7E, 8'h03, 8'h00, 8'h03, 8'h7D, 8'h7E,
            8'h7E, 8'h03, 8'h00, 8'h03, 8'h7E
        };
        addr_set  = '{8'h7E, 8'h00, 8'hFF};
        ctrl_set  = '{8'hFF, 8'h00, 8'h7D};
        stall_set = '{0, 64, 32};
        idle_set  = '{64, 0, 32};

        sb = new(MAX_PAYLOAD);
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = 8'h00;
        m_tready       = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = 3'd0;
        pwdata         = 32'h0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_budget    = 0;
        bytes_sent     = 0;
        cycle_count    = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_line[i]) send_byte(directed_line[i]);

        // Hold the result side off while a long frame streams in, so the queue
        // fills and the input stalls; the frame also saturates the length.
        hold_budget = HOLD_CYCLES;
        send_byte(FLAG_BYTE);
        send_byte(8'h03);
        send_byte(8'h00);
        send_byte(8'h03);
        repeat (MAX_PAYLOAD + 20) send_payload_byte(pick_payload());
        send_byte(FLAG_BYTE);
        send_random_until(TOTAL_BYTES / 4);

        for (int p = 0; p < 3; p++) begin
            wait_idle();
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            set_header(addr_set[p], ctrl_set[p]);
            send_random_until(TOTAL_BYTES * (p + 2) / 4);
        end
        wait_idle();

        if (sb.close_out() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
`default_nettype wire
